FILE: rtl/sbsm_pkg.sv
// Shared types and constants for the serial bank switch mapper.
// No dependencies; used by every module of the block.
package sbsm_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int MEM_ADDR_W  = 18;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [4:0] BANK_COUNT_RESET = 5'd16;
   localparam logic [4:0] CONTROL_RESET    = 5'h0C;
   localparam logic [4:0] CHR_HIGH_RESET   = 5'd1;
   localparam logic [3:0] PRG_HIGH_RESET   = 4'd15;
   localparam logic [2:0] LOAD_LAST        = 3'd4;

   localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

   typedef enum logic [1:0] {
      CMD_PRG_READ  = 2'd0,
      CMD_PRG_WRITE = 2'd1,
      CMD_CHR_READ  = 2'd2,
      CMD_CHR_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEL_NONE    = 2'd0,
      SEL_PRG_ROM = 2'd1,
      SEL_CHR_ROM = 2'd2,
      SEL_CHR_RAM = 2'd3
   } mem_sel_type;

   typedef enum logic [1:0] {
      TGT_CONTROL = 2'd0,
      TGT_CHR0    = 2'd1,
      TGT_CHR1    = 2'd2,
      TGT_PRG     = 2'd3
   } load_target_type;

   typedef enum logic [0:0] {
      REG_BANK_COUNT = 1'b0,
      REG_CHR_RAM    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic          wr_en;
      reg_index_type index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_bus_type;

   typedef struct packed {
      logic [3:0] prg_low;
      logic [3:0] prg_high;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic       chr_ram;
   } bank_state_type;

   typedef struct packed {
      mem_sel_type             sel;
      logic [MEM_ADDR_W-1:0]   addr;
      logic                    wr;
      logic [DATA_W-1:0]       wdata;
   } xlate_result_type;

endpackage

FILE: rtl/sbsm_regs.sv
// Serial loader, control and bank registers, and the CSR register file.
// Depends on sbsm_pkg.
module sbsm_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_accept,
   input  sbsm_pkg::cmd_type             cmd,
   input  logic [sbsm_pkg::ADDR_W-1:0]   address,
   input  logic [sbsm_pkg::DATA_W-1:0]   data,
   input  sbsm_pkg::csr_bus_type         csr,
   output logic [sbsm_pkg::CSR_DATA_W-1:0] csr_rdata,
   output sbsm_pkg::bank_state_type      bank_state,
   output logic [1:0]                    mirroring_in
);

   logic [4:0] bank_count_ff, bank_count_in;
   logic       chr_ram_ff, chr_ram_in;
   logic [4:0] load_shift_ff, load_shift_in;
   logic [2:0] load_count_ff, load_count_in;
   logic [4:0] control_ff, control_in;
   logic [3:0] prg_low_ff, prg_low_in;
   logic [3:0] prg_high_ff, prg_high_in;
   logic [4:0] chr_low_ff, chr_low_in;
   logic [4:0] chr_high_ff, chr_high_in;

   logic       prg_write;
   logic [4:0] shift_next;
   logic [3:0] last_bank;
   sbsm_pkg::load_target_type target;

   assign prg_write  = item_accept && (cmd == sbsm_pkg::CMD_PRG_WRITE) && address[15];
   assign shift_next = {data[0], load_shift_ff[4:1]};
   assign last_bank  = bank_count_ff[3:0] - 4'd1;
   assign target     = sbsm_pkg::load_target_type'(address[14:13]);

   always_comb begin
      bank_count_in = bank_count_ff;
      chr_ram_in    = chr_ram_ff;
      load_shift_in = load_shift_ff;
      load_count_in = load_count_ff;
      control_in    = control_ff;
      prg_low_in    = prg_low_ff;
      prg_high_in   = prg_high_ff;
      chr_low_in    = chr_low_ff;
      chr_high_in   = chr_high_ff;
      if (csr.wr_en) begin
         unique case (csr.index)
            sbsm_pkg::REG_BANK_COUNT: begin
               bank_count_in = csr.wdata[4:0];
               prg_high_in   = csr.wdata[3:0] - 4'd1;
            end
            sbsm_pkg::REG_CHR_RAM: begin
               chr_ram_in = csr.wdata[0];
            end
            default: ;
         endcase
      end else if (prg_write) begin
         if (data[7]) begin
            load_shift_in = '0;
            load_count_in = '0;
            control_in    = control_ff | sbsm_pkg::CONTROL_RESET;
         end else if (load_count_ff >= sbsm_pkg::LOAD_LAST) begin
            load_shift_in = '0;
            load_count_in = '0;
            unique case (target)
               sbsm_pkg::TGT_CONTROL: control_in = shift_next;
               sbsm_pkg::TGT_CHR0: begin
                  if (!control_ff[4]) begin
                     chr_low_in  = {shift_next[4:1], 1'b0};
                     chr_high_in = {shift_next[4:1], 1'b1};
                  end else begin
                     chr_low_in = shift_next;
                  end
               end
               sbsm_pkg::TGT_CHR1: begin
                  if (control_ff[4]) begin
                     chr_high_in = shift_next;
                  end
               end
               sbsm_pkg::TGT_PRG: begin
                  priority if (control_ff[3:2] == sbsm_pkg::PRG_MODE_FIX_LAST) begin
                     prg_low_in  = shift_next[3:0];
                     prg_high_in = last_bank;
                  end else if (control_ff[3:2] == sbsm_pkg::PRG_MODE_FIX_FIRST) begin
                     prg_low_in  = '0;
                     prg_high_in = shift_next[3:0];
                  end else begin
                     prg_low_in  = {shift_next[3:1], 1'b0};
                     prg_high_in = {shift_next[3:1], 1'b1};
                  end
               end
               default: ;
            endcase
         end else begin
            load_shift_in = shift_next;
            load_count_in = load_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff <= sbsm_pkg::BANK_COUNT_RESET;
         chr_ram_ff    <= 1'b0;
         load_shift_ff <= '0;
         load_count_ff <= '0;
         control_ff    <= sbsm_pkg::CONTROL_RESET;
         prg_low_ff    <= '0;
         prg_high_ff   <= sbsm_pkg::PRG_HIGH_RESET;
         chr_low_ff    <= '0;
         chr_high_ff   <= sbsm_pkg::CHR_HIGH_RESET;
      end else begin
         bank_count_ff <= bank_count_in;
         chr_ram_ff    <= chr_ram_in;
         load_shift_ff <= load_shift_in;
         load_count_ff <= load_count_in;
         control_ff    <= control_in;
         prg_low_ff    <= prg_low_in;
         prg_high_ff   <= prg_high_in;
         chr_low_ff    <= chr_low_in;
         chr_high_ff   <= chr_high_in;
      end
   end

   always_comb begin
      unique case (csr.index)
         sbsm_pkg::REG_BANK_COUNT: csr_rdata = {27'd0, bank_count_ff};
         sbsm_pkg::REG_CHR_RAM:    csr_rdata = {31'd0, chr_ram_ff};
         default:                  csr_rdata = '0;
      endcase
   end

   assign bank_state.prg_low  = prg_low_ff;
   assign bank_state.prg_high = prg_high_ff;
   assign bank_state.chr_low  = chr_low_ff;
   assign bank_state.chr_high = chr_high_ff;
   assign bank_state.chr_ram  = chr_ram_ff;
   assign mirroring_in        = control_in[1:0];

   // loader never runs past its fifth bit
   a_load_count_range: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= sbsm_pkg::LOAD_LAST)
      else $error("load count out of range");

   // reset beat on the serial port forces fix-last PRG mode and clears the loader
   a_reset_beat: assert property (@(posedge clock) disable iff (reset)
      (prg_write && data[7] && !csr.wr_en) |=>
      (control_ff[3:2] == sbsm_pkg::PRG_MODE_FIX_LAST) && (load_count_ff == 3'd0))
      else $error("reset beat did not clear loader");

   // bank count write reloads the last-bank register
   a_count_reload: assert property (@(posedge clock) disable iff (reset)
      (csr.wr_en && (csr.index == sbsm_pkg::REG_BANK_COUNT)) |=>
      (prg_high_ff == ($past(csr.wdata[3:0]) - 4'd1)))
      else $error("last bank not reloaded");

endmodule

FILE: rtl/sbsm_xlate.sv
// Address translation for PRG and CHR beats from the current bank state.
// Depends on sbsm_pkg.
module sbsm_xlate (
   input  sbsm_pkg::cmd_type             cmd,
   input  logic [sbsm_pkg::ADDR_W-1:0]   address,
   input  logic [sbsm_pkg::DATA_W-1:0]   data,
   input  sbsm_pkg::bank_state_type      bank_state,
   output sbsm_pkg::xlate_result_type    result
);

   logic       chr_window;
   logic [3:0] prg_bank;
   logic [4:0] chr_bank;

   assign chr_window = (address[15:13] == 3'd0);
   assign prg_bank   = address[14] ? bank_state.prg_high : bank_state.prg_low;
   assign chr_bank   = address[12] ? bank_state.chr_high : bank_state.chr_low;

   always_comb begin
      result.sel   = sbsm_pkg::SEL_NONE;
      result.addr  = '0;
      result.wr    = 1'b0;
      result.wdata = '0;
      unique case (cmd)
         sbsm_pkg::CMD_PRG_READ: begin
            if (address[15]) begin
               result.sel  = sbsm_pkg::SEL_PRG_ROM;
               result.addr = {prg_bank, address[13:0]};
            end
         end
         sbsm_pkg::CMD_PRG_WRITE: ;
         sbsm_pkg::CMD_CHR_READ: begin
            if (chr_window) begin
               result.sel  = bank_state.chr_ram ? sbsm_pkg::SEL_CHR_RAM
                                                : sbsm_pkg::SEL_CHR_ROM;
               result.addr = {1'b0, chr_bank, address[11:0]};
            end
         end
         sbsm_pkg::CMD_CHR_WRITE: begin
            if (chr_window && bank_state.chr_ram) begin
               result.sel   = sbsm_pkg::SEL_CHR_RAM;
               result.addr  = {5'd0, address[12:0]};
               result.wr    = 1'b1;
               result.wdata = data;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/serial_bank_switch_mapper.sv
// A result beat is registered and appears in the cycle after its request beat is taken.
// Throughput: one beat per cycle; a single output register holds the result,
// and a new request is taken whenever that register is empty or being drained.
// Reset (synchronous, active high) clears the loader and output valid and sets
// control 0x0C, bank count 16, last PRG bank 15, CHR banks 0 and 1.
// Depends on sbsm_pkg, sbsm_regs and sbsm_xlate.
module serial_bank_switch_mapper (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // address [15:0], data [23:16]
   input  logic [sbsm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // cmd [1:0]
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // mem_address [17:0], mem_write [18], write_data [26:19], mirroring [28:27]
   output logic [sbsm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // mem_select [1:0]
   output logic [1:0]                           rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sbsm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sbsm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sbsm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic                               item_accept;
   sbsm_pkg::cmd_type                  cmd;
   logic [sbsm_pkg::ADDR_W-1:0]        address;
   logic [sbsm_pkg::DATA_W-1:0]        data;
   sbsm_pkg::csr_bus_type              csr;
   sbsm_pkg::bank_state_type           bank_state;
   sbsm_pkg::xlate_result_type         result;
   logic [1:0]                         mirroring_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sbsm_pkg::RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                         rsp_tuser_ff, rsp_tuser_in;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign item_accept = req_tvalid && req_tready;
   assign cmd         = sbsm_pkg::cmd_type'(req_tuser);
   assign address     = req_tdata[15:0];
   assign data        = req_tdata[23:16];

   assign csr_pready  = 1'b1;
   assign csr.wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr.index   = sbsm_pkg::reg_index_type'(csr_paddr[2]);
   assign csr.wdata   = csr_pwdata;

   sbsm_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (item_accept),
      .cmd          (cmd),
      .address      (address),
      .data         (data),
      .csr          (csr),
      .csr_rdata    (csr_prdata),
      .bank_state   (bank_state),
      .mirroring_in (mirroring_in)
   );

   sbsm_xlate u_xlate (
      .cmd        (cmd),
      .address    (address),
      .data       (data),
      .bank_state (bank_state),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (item_accept) begin
         rsp_valid_in = 1'b1;
         rsp_tdata_in = {3'd0, mirroring_in, result.wdata, result.wr, result.addr};
         rsp_tuser_in = result.sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: dv/tb_serial_bank_switch_mapper.sv
// Self-checking testbench for serial_bank_switch_mapper. A shadow copy of the mapper
// predicts each result beat from the request beats and config writes it has seen.
// Depends on sbsm_pkg and the mapper RTL.
module tb_serial_bank_switch_mapper;

   localparam int CLOCK_HALF  = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 70;

   typedef struct packed {
      sbsm_pkg::mem_sel_type           sel;
      logic [sbsm_pkg::MEM_ADDR_W-1:0] addr;
      logic                            wr;
      logic [sbsm_pkg::DATA_W-1:0]     wdata;
      logic [1:0]                      mirror;
   } mapped_beat_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [sbsm_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [1:0]                       req_tuser   = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [sbsm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [sbsm_pkg::CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [sbsm_pkg::CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [sbsm_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                             csr_pready;

   // shadow mapper state
   logic [4:0] shadow_shift;
   logic [2:0] shadow_count;
   logic [4:0] shadow_control;
   logic [3:0] shadow_prg_low;
   logic [3:0] shadow_prg_high;
   logic [4:0] shadow_chr_low;
   logic [4:0] shadow_chr_high;
   logic [4:0] shadow_bank_count;
   logic       shadow_chr_ram;

   mapped_beat_type due_mappings[$];
   int mismatches      = 0;
   int beats_checked   = 0;
   int items_sent      = 0;
   int loads_committed = 0;
   int config_writes   = 0;
   int cycles          = 0;
   int receiver_hold   = 0;
   int receiver_stall  = 0;
   bit no_idle         = 1'b0;

   serial_bank_switch_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still due",
                  cycles, due_mappings.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic void note_failure(string text);
      if (mismatches < 10)
         $display("%s", text);
      mismatches++;
   endfunction

   function automatic string beat_text(mapped_beat_type beat);
      return $sformatf("sel=%0d addr=%05h wr=%0b wdata=%02h mir=%0d",
                       beat.sel, beat.addr, beat.wr, beat.wdata, beat.mirror);
   endfunction

   // Computes the result of one access and advances the shadow state.
   function automatic mapped_beat_type map_access(sbsm_pkg::cmd_type cmd,
                                                  logic [15:0] addr, logic [7:0] data);
      mapped_beat_type beat;
      logic [4:0]      v;
      beat = '0;
      case (cmd)
         sbsm_pkg::CMD_PRG_READ: if (addr[15]) begin
            beat.sel  = sbsm_pkg::SEL_PRG_ROM;
            beat.addr = {addr[14] ? shadow_prg_high : shadow_prg_low, addr[13:0]};
         end
         sbsm_pkg::CMD_PRG_WRITE: if (addr[15]) begin
            if (data[7]) begin
               shadow_shift   = '0;
               shadow_count   = '0;
               shadow_control = shadow_control | 5'h0C;
            end else begin
               shadow_shift = {data[0], shadow_shift[4:1]};
               shadow_count = shadow_count + 3'd1;
               if (shadow_count == 3'd5) begin
                  v = shadow_shift;
                  case (sbsm_pkg::load_target_type'(addr[14:13]))
                     sbsm_pkg::TGT_CONTROL: shadow_control = v;
                     sbsm_pkg::TGT_CHR0: begin
                        if (!shadow_control[4]) begin
                           shadow_chr_low  = v & 5'h1E;
                           shadow_chr_high = shadow_chr_low + 5'd1;
                        end else begin
                           shadow_chr_low = v;
                        end
                     end
                     sbsm_pkg::TGT_CHR1: if (shadow_control[4]) shadow_chr_high = v;
                     sbsm_pkg::TGT_PRG: begin
                        case (shadow_control[3:2])
                           sbsm_pkg::PRG_MODE_FIX_FIRST: begin
                              shadow_prg_low  = 4'd0;
                              shadow_prg_high = v[3:0];
                           end
                           sbsm_pkg::PRG_MODE_FIX_LAST: begin
                              shadow_prg_low  = v[3:0];
                              shadow_prg_high = shadow_bank_count[3:0] - 4'd1;
                           end
                           default: begin
                              shadow_prg_low  = v[3:0] & 4'hE;
                              shadow_prg_high = shadow_prg_low + 4'd1;
                           end
                        endcase
                     end
                  endcase
                  shadow_shift = '0;
                  shadow_count = '0;
                  loads_committed++;
               end
            end
         end
         sbsm_pkg::CMD_CHR_READ: if (addr[15:13] == 3'd0) begin
            beat.sel  = shadow_chr_ram ? sbsm_pkg::SEL_CHR_RAM : sbsm_pkg::SEL_CHR_ROM;
            beat.addr = {1'b0, addr[12] ? shadow_chr_high : shadow_chr_low, addr[11:0]};
         end
         sbsm_pkg::CMD_CHR_WRITE: if (addr[15:13] == 3'd0 && shadow_chr_ram) begin
            beat.sel   = sbsm_pkg::SEL_CHR_RAM;
            beat.addr  = {5'd0, addr[12:0]};
            beat.wr    = 1'b1;
            beat.wdata = data;
         end
      endcase
      beat.mirror = shadow_control[1:0];
      return beat;
   endfunction

   // Result receiver: long hold-offs first, then the per-beat stall.
   always @(negedge clock) begin
      if (receiver_hold > 0) begin
         rsp_tready = 1'b0;
         receiver_hold--;
      end else if (receiver_stall > 0) begin
         rsp_tready = 1'b0;
         receiver_stall--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      mapped_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sel    = sbsm_pkg::mem_sel_type'(rsp_tuser);
         got.addr   = rsp_tdata[17:0];
         got.wr     = rsp_tdata[18];
         got.wdata  = rsp_tdata[26:19];
         got.mirror = rsp_tdata[28:27];
         receiver_stall = idle_draw();
         beats_checked++;
         if (due_mappings.size() == 0) begin
            note_failure($sformatf("unexpected beat: %s", beat_text(got)));
         end else begin
            want = due_mappings.pop_front();
            if (got.sel !== want.sel || got.addr !== want.addr || got.wr !== want.wr ||
                got.wdata !== want.wdata || got.mirror !== want.mirror)
               note_failure($sformatf("beat %0d: want %s, got %s",
                                      beats_checked, beat_text(want), beat_text(got)));
         end
      end
   end

   task automatic send_access(sbsm_pkg::cmd_type cmd, logic [15:0] addr, logic [7:0] data);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = {data, addr};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      due_mappings.push_back(map_access(cmd, addr, data));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (due_mappings.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_access(sbsm_pkg::reg_index_type index, logic write,
                             logic [31:0] value, output logic [31:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Block must be idle. Writes a register, mirrors it and reads it back.
   task automatic write_setting(sbsm_pkg::reg_index_type index, logic [31:0] value);
      logic [31:0] rdata, stored;
      csr_access(index, 1'b1, value, rdata);
      if (index == sbsm_pkg::REG_BANK_COUNT) begin
         shadow_bank_count = value[4:0];
         shadow_prg_high   = value[3:0] - 4'd1;
         stored = {27'd0, value[4:0]};
      end else begin
         shadow_chr_ram = value[0];
         stored = {31'd0, value[0]};
      end
      config_writes++;
      csr_access(index, 1'b0, '0, rdata);
      if (rdata !== stored)
         note_failure($sformatf("register %s read back %08h, want %08h",
                                index.name(), rdata, stored));
   endtask

   // Five serial writes that land one register.
   task automatic load_register(sbsm_pkg::load_target_type target, logic [4:0] value);
      for (int i = 0; i < 5; i++)
         send_access(sbsm_pkg::CMD_PRG_WRITE, {1'b1, target, 13'($urandom)},
                     {1'b0, 6'($urandom), value[i]});
   endtask

   task automatic random_traffic(int count);
      int start, pick;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            load_register(sbsm_pkg::load_target_type'($urandom_range(0, 3)),
                          5'($urandom));
         end else if (pick < 50) begin
            // partial load cut short by a loader reset
            repeat ($urandom_range(1, 4))
               send_access(sbsm_pkg::CMD_PRG_WRITE, {1'b1, 15'($urandom)},
                           {1'b0, 7'($urandom)});
            send_access(sbsm_pkg::CMD_PRG_WRITE, {1'b1, 15'($urandom)},
                        {1'b1, 7'($urandom)});
         end else if (pick < 62) begin
            send_access(sbsm_pkg::CMD_PRG_READ,
                        {$urandom_range(0, 4) != 0, 15'($urandom)}, 8'($urandom));
         end else if (pick < 75) begin
            send_access(sbsm_pkg::CMD_CHR_READ,
                        $urandom_range(0, 3) != 0 ? {3'd0, 13'($urandom)}
                                                  : 16'($urandom),
                        8'($urandom));
         end else if (pick < 85) begin
            send_access(sbsm_pkg::CMD_CHR_WRITE,
                        $urandom_range(0, 3) != 0 ? {3'd0, 13'($urandom)}
                                                  : 16'($urandom),
                        8'($urandom));
         end else begin
            send_access(sbsm_pkg::cmd_type'($urandom_range(0, 3)), 16'($urandom),
                        8'($urandom));
         end
      end
   endtask

   task automatic test_reset_mapping();
      send_access(sbsm_pkg::CMD_PRG_READ, 16'h8000, 8'h00);
      send_access(sbsm_pkg::CMD_PRG_READ, 16'hFFFF, 8'hFF);
      send_access(sbsm_pkg::CMD_PRG_READ, 16'h7FFF, 8'h00);
      send_access(sbsm_pkg::CMD_PRG_WRITE, 16'h7FFF, 8'h01);
      send_access(sbsm_pkg::CMD_CHR_READ, 16'h0000, 8'h00);
      send_access(sbsm_pkg::CMD_CHR_READ, 16'h1FFF, 8'h00);
      send_access(sbsm_pkg::CMD_CHR_READ, 16'h2000, 8'h00);
      send_access(sbsm_pkg::CMD_CHR_WRITE, 16'h0ABC, 8'h5A);
   endtask

   task automatic test_serial_loader();
      send_access(sbsm_pkg::CMD_PRG_WRITE, 16'h8000, 8'h01);
      send_access(sbsm_pkg::CMD_PRG_WRITE, 16'hA000, 8'h00);
      send_access(sbsm_pkg::CMD_PRG_WRITE, 16'hFFFF, 8'hFF);
      // 4 KiB CHR, fix-first PRG, vertical mirroring
      load_register(sbsm_pkg::TGT_CONTROL, 5'h1A);
      load_register(sbsm_pkg::TGT_PRG, 5'h1F);
      send_access(sbsm_pkg::CMD_PRG_READ, 16'h8000, 8'h00);
      send_access(sbsm_pkg::CMD_PRG_READ, 16'hC000, 8'h00);
   endtask

   task automatic test_bank_count_extremes();
      drain_results();
      write_setting(sbsm_pkg::REG_BANK_COUNT, 32'd0);
      write_setting(sbsm_pkg::REG_CHR_RAM, 32'd1);
      send_access(sbsm_pkg::CMD_PRG_WRITE, 16'hE000, 8'h80);
      send_access(sbsm_pkg::CMD_PRG_READ, 16'hFFFF, 8'h00);
      send_access(sbsm_pkg::CMD_CHR_WRITE, 16'h1FFF, 8'hA5);
      send_access(sbsm_pkg::CMD_CHR_READ, 16'h0000, 8'h00);
      drain_results();
      write_setting(sbsm_pkg::REG_BANK_COUNT, 32'd1);
      send_access(sbsm_pkg::CMD_PRG_READ, 16'hC000, 8'h00);
   endtask

   task automatic test_config_phases();
      logic [4:0] counts[6];
      counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'($urandom_range(1, 16))};
      for (int p = 0; p < 6; p++) begin
         drain_results();
         write_setting(sbsm_pkg::REG_BANK_COUNT, {27'd0, counts[p]});
         write_setting(sbsm_pkg::REG_CHR_RAM, {31'd0, p[0]});
         random_traffic(PHASE_ITEMS);
      end
   endtask

   task automatic test_backpressure();
      drain_results();
      no_idle = 1'b1;
      receiver_hold = 80;
      random_traffic(30);
      drain_results();
      random_traffic(40);
      no_idle = 1'b0;
   endtask

   initial begin
      shadow_shift      = '0;
      shadow_count      = '0;
      shadow_control    = sbsm_pkg::CONTROL_RESET;
      shadow_prg_low    = '0;
      shadow_prg_high   = sbsm_pkg::PRG_HIGH_RESET;
      shadow_chr_low    = '0;
      shadow_chr_high   = sbsm_pkg::CHR_HIGH_RESET;
      shadow_bank_count = sbsm_pkg::BANK_COUNT_RESET;
      shadow_chr_ram    = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_reset_mapping();
      test_serial_loader();
      test_bank_count_extremes();
      test_config_phases();
      test_backpressure();
      drain_results();
      repeat (5) @(negedge clock);
      $display("Sent %0d access beats over %0d register settings, %0d serial loads landed;",
               items_sent, config_writes, loads_committed);
      $display("checked %0d result beats, %0d mismatches.", beats_checked, mismatches);
      if (mismatches == 0 && due_mappings.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
